>>> hdl/sphere_frustum_cull_defines.svh
// Assertion macros shared by the sphere frustum cull RTL.
`ifndef SPHERE_FRUSTUM_CULL_DEFINES_SVH
`define SPHERE_FRUSTUM_CULL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset.
`define SFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sphere_frustum_cull: assertion failed");

// Next-cycle implication, disabled while in reset.
`define SFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sphere_frustum_cull: assertion failed");

`else

`define SFC_ASSERT_IMP(lbl, ante, cons)
`define SFC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> hdl/sfc_pkg.sv
// Package with register map constants for the sphere frustum cull block.
package sfc_pkg;

  localparam int ADDR_WIDTH = 6;
  localparam int DATA_WIDTH = 64;
  localparam int REG_SHIFT  = 3;
  localparam int IDX_WIDTH  = ADDR_WIDTH - REG_SHIFT;
  localparam int COORD_FRAC = 8;
  localparam int NUM_PLANES = 5;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_CAMERA   = 3'd0,
    REG_FORWARD  = 3'd1,
    REG_TOP      = 3'd2,
    REG_BOTTOM   = 3'd3,
    REG_RIGHT    = 3'd4,
    REG_LEFT     = 3'd5,
    REG_NEAR_FAR = 3'd6,
    REG_FOG      = 3'd7
  } sfc_reg_e;

endpackage

>>> hdl/sfc_sphere_if.sv
// Valid/ready channel carrying one bounding sphere word.
interface sfc_sphere_if #(
  parameter int COORD_WIDTH = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic signed [COORD_WIDTH-1:0] center_z;
  logic        [COORD_WIDTH-2:0] sphere_radius;

  modport source (output valid, center_x, center_y, center_z, sphere_radius, input ready);
  modport sink   (input valid, center_x, center_y, center_z, sphere_radius, output ready);
endinterface

>>> hdl/sfc_vis_if.sv
// Valid/ready channel carrying one visibility result word.
interface sfc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

>>> hdl/sphere_frustum_cull.sv
// Pipelined bounding sphere versus view frustum culling block.
//
// Usage:
//   Program camera position, forward and side plane normals, near/far and
//   fog limits over the APB port while the block is idle. Each register sits
//   at byte address 8*index; reads return the stored value, pready is tied high.
//   Sphere words enter on sphere_i (valid/ready); one visibility word leaves
//   on result_o for each sphere, in order.
// Pipeline and throughput:
//   Four register stages: offset subtract, 15 products, three-term plane sums,
//   limit compares into the output register. While result_o does not stall
//   the pipeline, one sphere is taken every cycle.
// Reset:
//   All configuration registers clear to zero (every sphere then reads as
//   visible) and every pipeline valid bit clears.
// Stalls:
//   When result_o is not ready each stage holds only while the one after it
//   is full, so bubbles close up and sphere_i keeps accepting until all four
//   stages hold a word.
`include "sphere_frustum_cull_defines.svh"

module sphere_frustum_cull #(
  parameter int COORD_WIDTH  = 20,
  parameter int NORMAL_WIDTH = 18
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [sfc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [sfc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready,
  sfc_sphere_if.sink                     sphere_i,
  sfc_vis_if.source                      result_o
);

  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int PROD_W    = DIFF_W + NORMAL_WIDTH;
  localparam int DOT_W     = PROD_W + 2;
  localparam int CMP_W     = DOT_W + 1;
  localparam int NORM_FRAC = NORMAL_WIDTH - 2;
  localparam int RAD_W     = COORD_WIDTH - 1;
  localparam int NP        = sfc_pkg::NUM_PLANES;

  // configuration registers
  logic [3*COORD_WIDTH-1:0]  cam_q;
  logic [3*NORMAL_WIDTH-1:0] nrm_q [NP];
  logic [2*COORD_WIDTH-1:0]  near_far_q;
  logic [COORD_WIDTH:0]      fog_q;

  logic             cfg_wr;
  sfc_pkg::sfc_reg_e reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = sfc_pkg::sfc_reg_e'(paddr[sfc_pkg::ADDR_WIDTH-1:sfc_pkg::REG_SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q      <= '0;
      near_far_q <= '0;
      fog_q      <= '0;
      for (int p = 0; p < NP; p++) begin
        nrm_q[p] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        sfc_pkg::REG_CAMERA:   cam_q      <= pwdata[3*COORD_WIDTH-1:0];
        sfc_pkg::REG_FORWARD:  nrm_q[0]   <= pwdata[3*NORMAL_WIDTH-1:0];
        sfc_pkg::REG_TOP:      nrm_q[1]   <= pwdata[3*NORMAL_WIDTH-1:0];
        sfc_pkg::REG_BOTTOM:   nrm_q[2]   <= pwdata[3*NORMAL_WIDTH-1:0];
        sfc_pkg::REG_RIGHT:    nrm_q[3]   <= pwdata[3*NORMAL_WIDTH-1:0];
        sfc_pkg::REG_LEFT:     nrm_q[4]   <= pwdata[3*NORMAL_WIDTH-1:0];
        sfc_pkg::REG_NEAR_FAR: near_far_q <= pwdata[2*COORD_WIDTH-1:0];
        sfc_pkg::REG_FOG:      fog_q      <= pwdata[COORD_WIDTH:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfc_pkg::REG_CAMERA:   prdata = sfc_pkg::DATA_WIDTH'(cam_q);
      sfc_pkg::REG_FORWARD:  prdata = sfc_pkg::DATA_WIDTH'(nrm_q[0]);
      sfc_pkg::REG_TOP:      prdata = sfc_pkg::DATA_WIDTH'(nrm_q[1]);
      sfc_pkg::REG_BOTTOM:   prdata = sfc_pkg::DATA_WIDTH'(nrm_q[2]);
      sfc_pkg::REG_RIGHT:    prdata = sfc_pkg::DATA_WIDTH'(nrm_q[3]);
      sfc_pkg::REG_LEFT:     prdata = sfc_pkg::DATA_WIDTH'(nrm_q[4]);
      sfc_pkg::REG_NEAR_FAR: prdata = sfc_pkg::DATA_WIDTH'(near_far_q);
      sfc_pkg::REG_FOG:      prdata = sfc_pkg::DATA_WIDTH'(fog_q);
      default:               prdata = '0;
    endcase
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || result_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign sphere_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= sphere_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: offset from camera
  logic signed [COORD_WIDTH-1:0] cen [3];
  logic signed [COORD_WIDTH-1:0] cam [3];
  logic signed [DIFF_W-1:0]      diff_d [3];
  logic signed [DIFF_W-1:0]      d1_q [3];
  logic        [RAD_W-1:0]       r1_q;

  always_comb begin
    cen[0] = sphere_i.center_x;
    cen[1] = sphere_i.center_y;
    cen[2] = sphere_i.center_z;
    for (int i = 0; i < 3; i++) begin
      cam[i]    = $signed(cam_q[i*COORD_WIDTH +: COORD_WIDTH]);
      diff_d[i] = DIFF_W'(cen[i]) - DIFF_W'(cam[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && sphere_i.valid) begin
      d1_q <= diff_d;
      r1_q <= sphere_i.sphere_radius;
    end
  end

  // stage 2: per-axis products for every plane
  logic signed [NORMAL_WIDTH-1:0] nrm    [NP][3];
  logic signed [PROD_W-1:0]       prod_d [NP][3];
  logic signed [PROD_W-1:0]       p2_q   [NP][3];
  logic        [RAD_W-1:0]        r2_q;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int i = 0; i < 3; i++) begin
        nrm[p][i]    = $signed(nrm_q[p][i*NORMAL_WIDTH +: NORMAL_WIDTH]);
        prod_d[p][i] = PROD_W'(d1_q[i]) * PROD_W'(nrm[p][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      p2_q <= prod_d;
      r2_q <= r1_q;
    end
  end

  // stage 3: plane dot products
  logic signed [DOT_W-1:0] dot_d [NP];
  logic signed [DOT_W-1:0] dot3_q [NP];
  logic        [RAD_W-1:0] r3_q;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      dot_d[p] = DOT_W'(p2_q[p][0]) + DOT_W'(p2_q[p][1]) + DOT_W'(p2_q[p][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      dot3_q <= dot_d;
      r3_q   <= r2_q;
    end
  end

  // stage 4: limit compares
  logic signed [CMP_W-1:0] rad_s, depth_s, near_s, far_s, fog_s, lo_s, hi_s;
  logic                    vis_d, vis4_q;

  always_comb begin
    rad_s   = $signed(CMP_W'({r3_q, {NORM_FRAC{1'b0}}}));
    near_s  = $signed(CMP_W'({near_far_q[COORD_WIDTH-1:0], {NORM_FRAC{1'b0}}}));
    far_s   = $signed(CMP_W'({near_far_q[2*COORD_WIDTH-1:COORD_WIDTH], {NORM_FRAC{1'b0}}}));
    fog_s   = $signed(CMP_W'({fog_q[COORD_WIDTH-1:0], {NORM_FRAC{1'b0}}}));
    depth_s = CMP_W'(dot3_q[0]);
    lo_s    = depth_s + rad_s;
    hi_s    = depth_s - rad_s;
    vis_d   = !(lo_s < near_s) && !(hi_s > far_s) && !(fog_q[COORD_WIDTH] && (hi_s > fog_s));
    for (int p = 1; p < NP; p++) begin
      if (CMP_W'(dot3_q[p]) < -rad_s) vis_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      vis4_q <= vis_d;
    end
  end

  assign result_o.valid   = v4_q;
  assign result_o.visible = vis4_q;

  `SFC_ASSERT_NXT(a_accept_fills_s1, sphere_i.valid && sphere_i.ready, v1_q)
  `SFC_ASSERT_IMP(a_stall_only_full, !sphere_i.ready, v1_q && v2_q && v3_q && v4_q)
  `SFC_ASSERT_NXT(a_s1_holds, v1_q && !rdy2, v1_q && $stable(r1_q))
  `SFC_ASSERT_NXT(a_s3_to_out, v3_q && rdy4, v4_q)

endmodule

>>> test/tb.sv
// Testbench for sphere_frustum_cull: directed and random spheres, checked against pinned results or a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CLK_PERIOD   = 4;
  localparam int CW           = 20;
  localparam int NW           = 18;
  localparam int NFRAC        = NW - 2;
  localparam int RANDOM_WORDS = 840;
  localparam int SETTING_SPAN = 85;
  localparam int HOLD_CYCLES  = 60;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [CW-1:0] C_MIN = 20'sh80000;
  localparam logic signed [CW-1:0] C_MAX = 20'sh7FFFF;
  localparam logic [CW-2:0]        R_MAX = 19'h7FFFF;
  localparam logic [NW-1:0] N_ONE     = 18'h10000;
  localparam logic [NW-1:0] N_NEG_ONE = 18'h30000;
  localparam logic [NW-1:0] N_MAX     = 18'h1FFFF;
  localparam logic [NW-1:0] N_MIN     = 18'h20000;
  localparam logic [CW-1:0] BOX_NEAR  = 20'd256;
  localparam logic [CW-1:0] BOX_FAR   = 20'd25600;
  localparam logic [CW-1:0] BOX_FOG   = 20'd12800;

  typedef enum logic [2:0] {
    SET_NONE,
    SET_BOX,
    SET_NO_FOG,
    SET_ALL_ONES,
    SET_EXTREME,
    SET_RANDOM
  } setting_e;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [CW-2:0]        rad;
  } sphere_t;

  typedef struct packed {
    setting_e             setup;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [CW-2:0]        rad;
    logic                 pinned;
    logic                 pinned_vis;
  } cull_row_t;

  localparam int NUM_ROWS = 18;

  cull_row_t directed_rows [NUM_ROWS] = '{
    '{SET_NONE,   C_MIN, C_MIN, C_MIN, 19'd0, 1'b1, 1'b1},
    '{SET_NONE,   C_MAX, C_MAX, C_MAX, R_MAX, 1'b1, 1'b1},
    '{SET_NONE,   20'sd0, 20'sd0, 20'sd0, 19'd0, 1'b1, 1'b1},
    '{SET_BOX,    20'sd0, 20'sd0, 20'sd1000, 19'd0, 1'b1, 1'b1},
    '{SET_NONE,   20'sd0, 20'sd0, 20'sd255, 19'd0, 1'b1, 1'b0},
    '{SET_NONE,   20'sd0, 20'sd0, 20'sd255, 19'd1, 1'b1, 1'b1},
    '{SET_NONE,   20'sd0, 20'sd0, 20'sd12801, 19'd0, 1'b1, 1'b0},
    '{SET_NONE,   20'sd0, 20'sd0, 20'sd12801, 19'd1, 1'b1, 1'b1},
    '{SET_NONE,   20'sd0, 20'sd300, 20'sd1000, 19'd299, 1'b1, 1'b0},
    '{SET_NONE,   20'sd0, 20'sd300, 20'sd1000, 19'd300, 1'b1, 1'b1},
    '{SET_NONE,   20'sd300, 20'sd0, 20'sd1000, 19'd299, 1'b1, 1'b0},
    '{SET_NONE,   -20'sd300, 20'sd0, 20'sd1000, 19'd299, 1'b1, 1'b0},
    '{SET_NONE,   20'sd0, -20'sd300, 20'sd1000, 19'd299, 1'b1, 1'b0},
    '{SET_NONE,   C_MIN, C_MIN, C_MIN, R_MAX, 1'b0, 1'b0},
    '{SET_NONE,   C_MAX, C_MAX, C_MAX, 19'd0, 1'b0, 1'b0},
    '{SET_NO_FOG, 20'sd0, 20'sd0, 20'sd12801, 19'd0, 1'b1, 1'b1},
    '{SET_NONE,   20'sd0, 20'sd0, 20'sd25601, 19'd0, 1'b1, 1'b0},
    '{SET_NONE,   20'sd0, 20'sd0, 20'sd25601, 19'd1, 1'b1, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sfc_pkg::ADDR_WIDTH-1:0] paddr;
  logic [sfc_pkg::DATA_WIDTH-1:0] pwdata;
  logic [sfc_pkg::DATA_WIDTH-1:0] prdata;
  logic pready;

  sfc_sphere_if #(.COORD_WIDTH(CW)) sphere_bus ();
  sfc_vis_if vis_bus ();

  sphere_frustum_cull #(
    .COORD_WIDTH (CW),
    .NORMAL_WIDTH(NW)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sphere_i(sphere_bus.sink),
    .result_o(vis_bus.source)
  );

  logic [63:0] frustum_regs [8];
  logic        visible_q [$];
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          long_hold_req;
  int          fail_count;
  int          cycle_count;
  int          spheres_sent;
  int          visible_seen;
  int          culled_seen;
  int          settings_used;
  int          long_holds;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [63:0] reg_mask(sfc_pkg::sfc_reg_e idx);
    case (idx)
      sfc_pkg::REG_CAMERA:   return (64'd1 << (3 * CW)) - 1;
      sfc_pkg::REG_NEAR_FAR: return (64'd1 << (2 * CW)) - 1;
      sfc_pkg::REG_FOG:      return (64'd1 << (CW + 1)) - 1;
      default:               return (64'd1 << (3 * NW)) - 1;
    endcase
  endfunction

  function automatic logic [63:0] pack_normal(logic [NW-1:0] x, logic [NW-1:0] y,
                                              logic [NW-1:0] z);
    return {10'd0, z, y, x};
  endfunction

  function automatic int rand_signed(int k);
    return int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k);
  endfunction

  function automatic logic [NW-1:0] rand_normal_field();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return NW'($urandom);
      default: return NW'(rand_signed(NFRAC));
    endcase
  endfunction

  function automatic longint plane_dot(longint dx, longint dy, longint dz, logic [63:0] nreg);
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [NW-1:0] nz;
    nx = nreg[0 +: NW];
    ny = nreg[NW +: NW];
    nz = nreg[2 * NW +: NW];
    return dx * longint'(nx) + dy * longint'(ny) + dz * longint'(nz);
  endfunction

  function automatic logic predict_visible(sphere_t s);
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    longint dx, dy, dz, r, depth, near_lim, far_lim, fog_lim;
    logic vis;
    px = frustum_regs[sfc_pkg::REG_CAMERA][0 +: CW];
    py = frustum_regs[sfc_pkg::REG_CAMERA][CW +: CW];
    pz = frustum_regs[sfc_pkg::REG_CAMERA][2 * CW +: CW];
    dx = longint'(s.cx) - longint'(px);
    dy = longint'(s.cy) - longint'(py);
    dz = longint'(s.cz) - longint'(pz);
    r = longint'(s.rad) << NFRAC;
    near_lim = longint'(frustum_regs[sfc_pkg::REG_NEAR_FAR][0 +: CW]) << NFRAC;
    far_lim = longint'(frustum_regs[sfc_pkg::REG_NEAR_FAR][CW +: CW]) << NFRAC;
    fog_lim = longint'(frustum_regs[sfc_pkg::REG_FOG][0 +: CW]) << NFRAC;
    depth = plane_dot(dx, dy, dz, frustum_regs[sfc_pkg::REG_FORWARD]);
    vis = 1'b1;
    if (depth + r < near_lim || depth - r > far_lim ||
        (frustum_regs[sfc_pkg::REG_FOG][CW] && depth - r > fog_lim)) begin
      vis = 1'b0;
    end
    for (int i = sfc_pkg::REG_TOP; i <= sfc_pkg::REG_LEFT; i++) begin
      if (plane_dot(dx, dy, dz, frustum_regs[i]) < -r) begin
        vis = 1'b0;
      end
    end
    return vis;
  endfunction

  function automatic sphere_t random_sphere();
    sphere_t s;
    int k;
    k = $urandom_range(4, 19);
    if ($urandom_range(0, 9) == 0) begin
      s.cx = CW'($urandom);
      s.cy = CW'($urandom);
      s.cz = CW'($urandom);
      s.rad = (CW - 1)'($urandom);
    end else begin
      s.cx = CW'(int'($signed(frustum_regs[sfc_pkg::REG_CAMERA][0 +: CW])) + rand_signed(k));
      s.cy = CW'(int'($signed(frustum_regs[sfc_pkg::REG_CAMERA][CW +: CW])) + rand_signed(k));
      s.cz = CW'(int'($signed(frustum_regs[sfc_pkg::REG_CAMERA][2 * CW +: CW]))
                 + rand_signed(k));
      s.rad = (CW - 1)'($urandom_range(0, 1 << k));
    end
    return s;
  endfunction

  task automatic write_reg(sfc_pkg::sfc_reg_e idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sfc_pkg::ADDR_WIDTH'(idx) << sfc_pkg::REG_SHIFT;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    frustum_regs[idx] = val & reg_mask(idx);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(setting_e kind);
    logic [CW-1:0] near_d;
    logic [CW-1:0] far_d;
    logic [63:0] val;
    settings_used++;
    case (kind)
      SET_BOX: begin
        write_reg(sfc_pkg::REG_CAMERA, 64'd0);
        write_reg(sfc_pkg::REG_FORWARD, pack_normal('0, '0, N_ONE));
        write_reg(sfc_pkg::REG_TOP, pack_normal('0, N_NEG_ONE, '0));
        write_reg(sfc_pkg::REG_BOTTOM, pack_normal('0, N_ONE, '0));
        write_reg(sfc_pkg::REG_RIGHT, pack_normal(N_NEG_ONE, '0, '0));
        write_reg(sfc_pkg::REG_LEFT, pack_normal(N_ONE, '0, '0));
        write_reg(sfc_pkg::REG_NEAR_FAR, {24'd0, BOX_FAR, BOX_NEAR});
        write_reg(sfc_pkg::REG_FOG, {43'd0, 1'b1, BOX_FOG});
      end
      SET_NO_FOG: begin
        write_reg(sfc_pkg::REG_FOG, {43'd0, 1'b0, BOX_FOG});
      end
      SET_ALL_ONES: begin
        for (int i = 0; i < 8; i++) begin
          write_reg(sfc_pkg::sfc_reg_e'(i), '1);
        end
      end
      SET_EXTREME: begin
        write_reg(sfc_pkg::REG_CAMERA, {4'd0, C_MIN, C_MIN, C_MIN});
        write_reg(sfc_pkg::REG_FORWARD, pack_normal(N_MAX, N_MAX, N_MAX));
        write_reg(sfc_pkg::REG_TOP, pack_normal(N_MIN, N_MIN, N_MIN));
        write_reg(sfc_pkg::REG_BOTTOM, pack_normal(N_MIN, '0, N_MAX));
        write_reg(sfc_pkg::REG_RIGHT, pack_normal('0, N_MAX, N_MIN));
        write_reg(sfc_pkg::REG_LEFT, pack_normal(N_MAX, N_MIN, '0));
        write_reg(sfc_pkg::REG_NEAR_FAR, {24'd0, 20'hFFFFF, 20'h00000});
        write_reg(sfc_pkg::REG_FOG, {43'd0, 1'b1, 20'hFFFFF});
      end
      default: begin
        for (int i = 0; i < 8; i++) begin
          case (sfc_pkg::sfc_reg_e'(i))
            sfc_pkg::REG_CAMERA: begin
              val = {4'd0, CW'(rand_signed($urandom_range(0, 19))),
                     CW'(rand_signed($urandom_range(0, 19))),
                     CW'(rand_signed($urandom_range(0, 19)))};
            end
            sfc_pkg::REG_NEAR_FAR: begin
              near_d = CW'($urandom_range(0, 1 << 14));
              far_d = CW'(near_d + $urandom_range(0, 1 << 19));
              val = {24'd0, far_d, near_d};
            end
            sfc_pkg::REG_FOG: begin
              val = {43'd0, 1'($urandom_range(0, 1)), CW'($urandom)};
            end
            default: begin
              val = pack_normal(rand_normal_field(), rand_normal_field(), rand_normal_field());
            end
          endcase
          val = val | ({$urandom, $urandom} & ~reg_mask(sfc_pkg::sfc_reg_e'(i)));
          write_reg(sfc_pkg::sfc_reg_e'(i), val);
        end
      end
    endcase
  endtask

  task automatic drain_results();
    sphere_bus.valid <= 1'b0;
    @(posedge clk);
    while (visible_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_sphere(sphere_t s, logic want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      sphere_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sphere_bus.valid <= 1'b1;
    sphere_bus.center_x <= s.cx;
    sphere_bus.center_y <= s.cy;
    sphere_bus.center_z <= s.cz;
    sphere_bus.sphere_radius <= s.rad;
    do @(posedge clk); while (!sphere_bus.ready);
    visible_q.push_back(want);
    spheres_sent++;
  endtask

  initial begin
    int hold_left;
    vis_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        vis_bus.ready <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(posedge clk);
      end else begin
        vis_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic want_vis;
    if (rst_n && vis_bus.valid && vis_bus.ready) begin
      if (visible_q.size() == 0) begin
        $error("visible: word with nothing expected, actual %0b", vis_bus.visible);
        fail_count++;
      end else begin
        want_vis = visible_q.pop_front();
        if (vis_bus.visible !== want_vis) begin
          $error("visible mismatch: expected %0b actual %0b", want_vis, vis_bus.visible);
          fail_count++;
        end
        if (want_vis) visible_seen++;
        else culled_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    sphere_t s;
    logic want;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sphere_bus.valid = 1'b0;
    sphere_bus.center_x = '0;
    sphere_bus.center_y = '0;
    sphere_bus.center_z = '0;
    sphere_bus.sphere_radius = '0;
    long_hold_req = 1'b0;
    send_idle_pct = 13;
    recv_idle_pct = 48;
    for (int i = 0; i < 8; i++) frustum_regs[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < NUM_ROWS; n++) begin
      if (directed_rows[n].setup != SET_NONE) begin
        drain_results();
        apply_setting(directed_rows[n].setup);
      end
      s.cx = directed_rows[n].cx;
      s.cy = directed_rows[n].cy;
      s.cz = directed_rows[n].cz;
      s.rad = directed_rows[n].rad;
      want = directed_rows[n].pinned ? directed_rows[n].pinned_vis : predict_visible(s);
      send_sphere(s, want);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 13;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (n % SETTING_SPAN == 0) begin
        drain_results();
        apply_setting(n == 0 ? SET_ALL_ONES :
                      n == SETTING_SPAN ? SET_EXTREME : SET_RANDOM);
      end
      if (n % (RANDOM_WORDS / 3) == SETTING_SPAN / 2) long_hold_req = 1'b1;
      s = random_sphere();
      send_sphere(s, predict_visible(s));
    end

    sphere_bus.valid <= 1'b0;
    @(posedge clk);
    while (visible_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d spheres over %0d frustum settings with %0d long output holds",
             spheres_sent, settings_used, long_holds);
    $display("Results: %0d visible, %0d culled, %0d mismatches",
             visible_seen, culled_seen, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
